// ----- design/itr_pkg.sv -----
`timescale 1ns / 1ps
package itr_pkg;

   // Operator stack sizing
   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Input token kinds
   localparam logic [2:0] TK_VAR   = 3'd0;
   localparam logic [2:0] TK_CONST = 3'd1;
   localparam logic [2:0] TK_OPER  = 3'd2;
   localparam logic [2:0] TK_LBR   = 3'd3;
   localparam logic [2:0] TK_RBR   = 3'd4;
   localparam logic [2:0] TK_COMMA = 3'd5;
   localparam logic [2:0] TK_END   = 3'd6;

   // Result kinds
   localparam logic [1:0] OK_VAR    = 2'd0;
   localparam logic [1:0] OK_OPER   = 2'd1;
   localparam logic [1:0] OK_CONST  = 2'd2;
   localparam logic [1:0] OK_STATUS = 2'd3;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NO_LBR   = 3'd1;
   localparam logic [2:0] ERR_NO_RBR   = 3'd2;
   localparam logic [2:0] ERR_MISUSE   = 3'd3;
   localparam logic [2:0] ERR_OVERFLOW = 3'd4;

   // Operator and function codes
   localparam logic [4:0] OP_ADD        = 5'd0;
   localparam logic [4:0] OP_SUB        = 5'd1;
   localparam logic [4:0] OP_DIV        = 5'd3;
   localparam logic [4:0] OP_POW        = 5'd4;
   localparam logic [4:0] FUNC_BASE     = 5'd5;
   localparam logic [4:0] CODE_NEG      = 5'd6;
   localparam logic [4:0] CONSUME_LIMIT = 5'd6;
   localparam logic [4:0] CODE_LIMIT    = 5'd26;
   localparam logic [4:0] BRACKET_MARK  = 5'd31;

   // Previous token class
   localparam logic [1:0] PC_NONE  = 2'd0;
   localparam logic [1:0] PC_LBR   = 2'd1;
   localparam logic [1:0] PC_OPER  = 2'd2;
   localparam logic [1:0] PC_OTHER = 2'd3;

   // Operand balance limits
   localparam logic signed [7:0] BAL_MAX = 8'sd127;
   localparam logic signed [7:0] BAL_MIN = -8'sd128;
   localparam logic signed [7:0] BAL_ONE = 8'sd1;

   // Classified command handed from front to back
   typedef enum logic [2:0] {
      CMD_VAR   = 3'd0,
      CMD_CONST = 3'd1,
      CMD_OPER  = 3'd2,
      CMD_LBR   = 3'd3,
      CMD_RBR   = 3'd4,
      CMD_COMMA = 3'd5,
      CMD_END   = 3'd6
   } cmd_class_type;

   typedef struct packed {
      cmd_class_type cls;
      logic [4:0]    code;
      logic [63:0]   re;
      logic [63:0]   im;
   } cmd_type;

   // Binary operators and negate take part in precedence popping
   function automatic logic is_op(input logic [4:0] c);
      return (c <= OP_POW) || (c == CODE_NEG);
   endfunction

   function automatic logic [2:0] prec(input logic [4:0] c);
      logic [2:0] p;
      if (c <= OP_SUB) begin
         p = 3'd1;
      end else if (c <= OP_DIV) begin
         p = 3'd2;
      end else if (c == CODE_NEG) begin
         p = 3'd3;
      end else begin
         p = 3'd4;
      end
      return p;
   endfunction

endpackage

// ----- design/itr_if.sv -----
`timescale 1ns / 1ps
interface itr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [4:0]  op_code;
   logic [63:0] const_real;
   logic [63:0] const_imag;

   modport source (output valid, token_kind, op_code, const_real, const_imag,
                   input ready);
   modport sink (input valid, token_kind, op_code, const_real, const_imag,
                 output ready);
endinterface

interface itr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  out_kind;
   logic [4:0]  out_code;
   logic [63:0] out_real;
   logic [63:0] out_imag;
   logic [2:0]  error_code;
   logic        last;

   modport source (output valid, out_kind, out_code, out_real, out_imag, error_code, last,
                   input ready);
   modport sink (input valid, out_kind, out_code, out_real, out_imag, error_code, last,
                 output ready);
endinterface

// ----- design/itr_front.sv -----
`timescale 1ns / 1ps
module itr_front import itr_pkg::*; (
   itr_req_if.sink  req_ch,
   input  logic     q_full,
   output logic     q_push,
   output cmd_type  q_cmd
);

   logic keep;

   // Classify the request and drop codes that mean nothing
   always_comb begin
      keep        = 1'b1;
      q_cmd.code  = req_ch.op_code;
      q_cmd.re    = req_ch.const_real;
      q_cmd.im    = req_ch.const_imag;
      q_cmd.cls   = CMD_VAR;
      case (req_ch.token_kind)
         TK_VAR: begin
            q_cmd.cls = CMD_VAR;
         end
         TK_CONST: begin
            q_cmd.cls = CMD_CONST;
         end
         TK_OPER: begin
            q_cmd.cls = CMD_OPER;
            keep      = (req_ch.op_code < CODE_LIMIT);
         end
         TK_LBR: begin
            q_cmd.cls = CMD_LBR;
         end
         TK_RBR: begin
            q_cmd.cls = CMD_RBR;
         end
         TK_COMMA: begin
            q_cmd.cls = CMD_COMMA;
         end
         TK_END: begin
            q_cmd.cls = CMD_END;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Accept whenever the queue has room
   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full && keep;

endmodule

// ----- design/itr_cmd_queue.sv -----
`timescale 1ns / 1ps
module itr_cmd_queue import itr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold entries until popped
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- design/itr_back.sv -----
`timescale 1ns / 1ps
module itr_back import itr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  cmd_type   q_cmd,
   output logic      q_pop,
   itr_rsp_if.source rsp_ch
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_OPPOP  = 7'b0000010,
      ST_RPOP   = 7'b0000100,
      ST_RFUNC  = 7'b0001000,
      ST_CPOP   = 7'b0010000,
      ST_EPOP   = 7'b0100000,
      ST_STATUS = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [4:0]        stack_ff [STACK_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic signed [7:0] bal_ff, bal_in;
   logic              has_out_ff, has_out_in;
   logic [1:0]        prev_ff, prev_in;
   logic [2:0]        err_ff, err_in;
   logic [4:0]        cur_ff, cur_in;

   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff;
   logic [4:0]        code_ff;
   logic [63:0]       re_ff, im_ff;
   logic [2:0]        ecode_ff;
   logic              last_ff;

   logic              out_free;
   logic [IDX_W-1:0]  top_idx;
   logic [4:0]        top;
   logic              nonempty;
   logic              top_pops;
   logic              unary;
   logic              push_req, push_en;
   logic [4:0]        push_val;
   logic              emit;
   logic [1:0]        emit_kind;
   logic [4:0]        emit_code;
   logic [63:0]       emit_re, emit_im;
   logic [2:0]        emit_err;
   logic              emit_last;

   assign out_free = !valid_ff || rsp_ch.ready;
   assign top_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign top      = stack_ff[top_idx];
   assign nonempty = (count_ff != '0);
   assign top_pops = is_op(top) && ((prec(top) > prec(cur_ff)) ||
                     ((prec(top) == prec(cur_ff)) && (cur_ff != OP_POW)));
   assign unary    = (q_cmd.code == OP_SUB) &&
                     ((!has_out_ff && !nonempty) || (prev_ff == PC_LBR) ||
                      (prev_ff == PC_OPER));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      bal_in     = bal_ff;
      has_out_in = has_out_ff;
      prev_in    = prev_ff;
      err_in     = err_ff;
      cur_in     = cur_ff;
      q_pop      = 1'b0;
      push_req   = 1'b0;
      push_en    = 1'b0;
      push_val   = q_cmd.code;
      emit       = 1'b0;
      emit_kind  = OK_OPER;
      emit_code  = top;
      emit_re    = '0;
      emit_im    = '0;
      emit_err   = ERR_NONE;
      emit_last  = 1'b0;

      // Sequence one command, at most one result per cycle
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if ((err_ff != ERR_NONE) && (q_cmd.cls != CMD_END)) begin
                  q_pop = 1'b1;
               end else begin
                  case (q_cmd.cls)
                     CMD_VAR: begin
                        if (out_free) begin
                           q_pop     = 1'b1;
                           emit      = 1'b1;
                           emit_kind = OK_VAR;
                           emit_code = '0;
                           prev_in   = PC_OTHER;
                        end
                     end
                     CMD_CONST: begin
                        if (out_free) begin
                           q_pop     = 1'b1;
                           emit      = 1'b1;
                           emit_kind = OK_CONST;
                           emit_code = '0;
                           emit_re   = q_cmd.re;
                           emit_im   = q_cmd.im;
                           prev_in   = PC_OTHER;
                        end
                     end
                     CMD_OPER: begin
                        q_pop = 1'b1;
                        if (q_cmd.code >= FUNC_BASE) begin
                           push_req = 1'b1;
                           prev_in  = (q_cmd.code == CODE_NEG) ? PC_OPER : PC_OTHER;
                        end else if (unary) begin
                           push_req = 1'b1;
                           push_val = CODE_NEG;
                           prev_in  = PC_OPER;
                        end else begin
                           cur_in   = q_cmd.code;
                           state_in = ST_OPPOP;
                        end
                     end
                     CMD_LBR: begin
                        q_pop    = 1'b1;
                        push_req = 1'b1;
                        push_val = BRACKET_MARK;
                        prev_in  = PC_LBR;
                     end
                     CMD_RBR: begin
                        q_pop    = 1'b1;
                        state_in = ST_RPOP;
                     end
                     CMD_COMMA: begin
                        q_pop    = 1'b1;
                        state_in = ST_CPOP;
                     end
                     CMD_END: begin
                        q_pop    = 1'b1;
                        state_in = (err_ff != ERR_NONE) ? ST_STATUS : ST_EPOP;
                     end
                     default: begin
                        q_pop = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_OPPOP: begin
            // Pop operators that bind tighter, or as tight unless the new one is power, then push the new one
            if (nonempty && top_pops) begin
               if (out_free) begin
                  emit     = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else begin
               push_req = 1'b1;
               push_val = cur_ff;
               prev_in  = PC_OPER;
               state_in = ST_IDLE;
            end
         end
         ST_RPOP: begin
            // Pop to the bracket, drop it, then pop a function or operator above it
            if (nonempty && (top != BRACKET_MARK)) begin
               if (out_free) begin
                  emit     = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else if (!nonempty) begin
               if (err_in == ERR_NONE) begin
                  err_in = ERR_NO_LBR;
               end
               prev_in  = PC_OTHER;
               state_in = ST_IDLE;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = ST_RFUNC;
            end
         end
         ST_RFUNC: begin
            if (nonempty && (top != BRACKET_MARK)) begin
               if (out_free) begin
                  emit     = 1'b1;
                  count_in = count_ff - 1'b1;
                  prev_in  = PC_OTHER;
                  state_in = ST_IDLE;
               end
            end else begin
               prev_in  = PC_OTHER;
               state_in = ST_IDLE;
            end
         end
         ST_CPOP: begin
            if (nonempty && (top != BRACKET_MARK)) begin
               if (out_free) begin
                  emit     = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else begin
               prev_in  = PC_OTHER;
               state_in = ST_IDLE;
            end
         end
         ST_EPOP: begin
            // Flush the stack; a leftover bracket stops the flush
            if (nonempty) begin
               if (top == BRACKET_MARK) begin
                  if (err_in == ERR_NONE) begin
                     err_in = ERR_NO_RBR;
                  end
                  count_in = count_ff - 1'b1;
                  state_in = ST_STATUS;
               end else if (out_free) begin
                  emit     = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end else begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            // Report and return to the reset state
            if (out_free) begin
               emit       = 1'b1;
               emit_kind  = OK_STATUS;
               emit_code  = '0;
               emit_last  = 1'b1;
               if (err_ff != ERR_NONE) begin
                  emit_err = err_ff;
               end else if (bal_ff != BAL_ONE) begin
                  emit_err = ERR_MISUSE;
               end else begin
                  emit_err = ERR_NONE;
               end
               count_in   = '0;
               bal_in     = '0;
               has_out_in = 1'b0;
               prev_in    = PC_NONE;
               err_in     = ERR_NONE;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Push onto the stack, or flag overflow when full
      if (push_req) begin
         if (count_ff >= CNT_W'(STACK_DEPTH)) begin
            if (err_in == ERR_NONE) begin
               err_in = ERR_OVERFLOW;
            end
         end else begin
            push_en  = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end

      // Track operand balance of emitted tokens
      if (emit && (emit_kind != OK_STATUS)) begin
         has_out_in = 1'b1;
         if ((emit_kind == OK_VAR) || (emit_kind == OK_CONST)) begin
            if (bal_ff == BAL_MAX) begin
               if (err_in == ERR_NONE) begin
                  err_in = ERR_OVERFLOW;
               end
            end else begin
               bal_in = bal_ff + 8'sd1;
            end
         end else if (emit_code < CONSUME_LIMIT) begin
            if (bal_ff == BAL_MIN) begin
               if (err_in == ERR_NONE) begin
                  err_in = ERR_OVERFLOW;
               end
            end else begin
               bal_in = bal_ff - 8'sd1;
            end
         end
      end

      // Hold the result until taken
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         bal_ff     <= '0;
         has_out_ff <= 1'b0;
         prev_ff    <= PC_NONE;
         err_ff     <= ERR_NONE;
         valid_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         bal_ff     <= bal_in;
         has_out_ff <= has_out_in;
         prev_ff    <= prev_in;
         err_ff     <= err_in;
         valid_ff   <= valid_in;
      end
   end

   // Payload and stack storage
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (push_en) begin
         stack_ff[count_ff[IDX_W-1:0]] <= push_val;
      end
      if (emit) begin
         kind_ff  <= emit_kind;
         code_ff  <= emit_code;
         re_ff    <= emit_re;
         im_ff    <= emit_im;
         ecode_ff <= emit_err;
         last_ff  <= emit_last;
      end
   end

   assign rsp_ch.valid      = valid_ff;
   assign rsp_ch.out_kind   = kind_ff;
   assign rsp_ch.out_code   = code_ff;
   assign rsp_ch.out_real   = re_ff;
   assign rsp_ch.out_imag   = im_ff;
   assign rsp_ch.error_code = ecode_ff;
   assign rsp_ch.last       = last_ff;

endmodule

// ----- design/infix_to_rpn_shunting_yard_unit.sv -----
`timescale 1ns / 1ps
// Infix to reverse Polish converter: takes classified formula tokens on req_ch and
// emits postfix tokens on rsp_ch, closing each formula with one status result
// (last = 1) that carries the first error seen. A front stage accepts a request
// whenever the two-entry command queue has room and drops unknown token kinds and
// operator codes above 25 there. The back sequencer sees the queue head the cycle
// after it is written and runs one command at a time against a 32-entry operator
// stack. It forms at most one result per cycle, and that result is valid on rsp_ch
// the next cycle. A variable, constant, function, unary minus, left bracket, or any
// token ignored after an error is handled as it leaves the queue. A binary operator
// first pops each stacked operator that outranks it, then is pushed. A right bracket
// pops to its bracket, drops it, then pops a function or operator sitting above it;
// a missing bracket is flagged. A comma pops to the bracket. The end token flushes
// the stack and then reports status, or only reports status when an error is pending.
// A cycle that forms a result waits while the result register holds a result not yet
// taken. Stack pops go one at a time, through the single read port and result register.
module infix_to_rpn_shunting_yard_unit import itr_pkg::*; (
   input logic       clock,
   input logic       reset,
   itr_req_if.sink   req_ch,
   itr_rsp_if.source rsp_ch
);

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_in_cmd, q_head_cmd;

   itr_front u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_in_cmd)
   );

   itr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_in_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   itr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_cmd   (q_head_cmd),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ----- dv/tb_infix_to_rpn_shunting_yard_unit.sv -----
`timescale 1ns / 1ps
module tb_infix_to_rpn_shunting_yard_unit import itr_pkg::*;;

   // Token and operator codes the package leaves unnamed, and run sizes
   localparam logic [2:0]  TK_BAD     = 3'd7;
   localparam logic [4:0]  OP_MUL     = 5'd2;
   localparam logic [4:0]  OP_UNUSED  = 5'd31;
   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          DRAIN_CYCLES   = 50;
   localparam int          RANDOM_ITEMS   = 230;
   localparam int          PRINT_LIMIT    = 100;

   typedef struct {
      logic [2:0]  kind;
      logic [4:0]  code;
      logic [63:0] re;
      logic [63:0] im;
   } token_req_type;

   typedef struct {
      logic [1:0]  kind;
      logic [4:0]  code;
      logic [63:0] re;
      logic [63:0] im;
      logic [2:0]  err;
      logic        last;
   } rpn_token_type;

   // Converter state mirror and queue of postfix tokens still owed by the block
   class rpn_scoreboard;
      rpn_token_type expected_q[$];
      int            mismatches;
      int            checked;
      logic [4:0]    stack_mem[STACK_DEPTH];
      int            depth;
      int            balance;
      bit            emitted;
      logic [1:0]    prev_cls;
      logic [2:0]    first_err;

      function new();
         mismatches = 0;
         checked    = 0;
         clear_state();
      endfunction

      function void clear_state();
         foreach (stack_mem[i]) stack_mem[i] = '0;
         depth     = 0;
         balance   = 0;
         emitted   = 1'b0;
         prev_cls  = PC_NONE;
         first_err = ERR_NONE;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void flag_error(input logic [2:0] e);
         if (first_err == ERR_NONE) first_err = e;
      endfunction

      // Binding strength of a stacked code, zero for brackets and functions
      function int op_strength(input logic [4:0] c);
         if (c <= OP_SUB) return 1;
         if (c <= OP_DIV) return 2;
         if (c == OP_POW) return 4;
         if (c == CODE_NEG) return 3;
         return 0;
      endfunction

      function bit outranks(input logic [4:0] top, input logic [4:0] incoming);
         int s_top;
         int s_in;
         s_top = op_strength(top);
         s_in  = op_strength(incoming);
         return (s_top != 0) && (s_top > s_in || (s_top == s_in && incoming != OP_POW));
      endfunction

      // Queue one postfix token and track the operand balance
      function void emit(input logic [1:0] kind, input logic [4:0] code,
                         input logic [63:0] re, input logic [63:0] im,
                         input logic [2:0] err, input logic last);
         rpn_token_type t;
         t.kind = kind;
         t.code = code;
         t.re   = re;
         t.im   = im;
         t.err  = err;
         t.last = last;
         expected_q.push_back(t);
         if (kind == OK_STATUS) return;
         emitted = 1'b1;
         if (kind == OK_VAR || kind == OK_CONST) begin
            if (balance >= int'(BAL_MAX)) flag_error(ERR_OVERFLOW);
            else balance++;
         end else if (code < CONSUME_LIMIT) begin
            if (balance <= int'(BAL_MIN)) flag_error(ERR_OVERFLOW);
            else balance--;
         end
      endfunction

      function void push_op(input logic [4:0] c);
         if (depth >= STACK_DEPTH) begin
            flag_error(ERR_OVERFLOW);
            return;
         end
         stack_mem[depth] = c;
         depth++;
      endfunction

      function void unwind_to_bracket();
         while (depth != 0 && stack_mem[depth - 1] != BRACKET_MARK) begin
            depth--;
            emit(OK_OPER, stack_mem[depth], '0, '0, ERR_NONE, 1'b0);
         end
      endfunction

      // Work out the postfix tokens one accepted request produces
      function void note_request(input token_req_type t);
         logic [4:0] top;
         if (t.kind == TK_END) begin
            if (first_err == ERR_NONE) begin
               while (depth != 0) begin
                  depth--;
                  top = stack_mem[depth];
                  if (top == BRACKET_MARK) begin
                     flag_error(ERR_NO_RBR);
                     break;
                  end
                  emit(OK_OPER, top, '0, '0, ERR_NONE, 1'b0);
               end
               if (first_err == ERR_NONE && balance != int'(BAL_ONE)) flag_error(ERR_MISUSE);
            end
            emit(OK_STATUS, '0, '0, '0, first_err, 1'b1);
            clear_state();
            return;
         end
         if (first_err != ERR_NONE || t.kind > TK_END) return;
         case (t.kind)
            TK_VAR: begin
               emit(OK_VAR, '0, '0, '0, ERR_NONE, 1'b0);
               prev_cls = PC_OTHER;
            end
            TK_CONST: begin
               emit(OK_CONST, '0, t.re, t.im, ERR_NONE, 1'b0);
               prev_cls = PC_OTHER;
            end
            TK_OPER: begin
               if (t.code >= CODE_LIMIT) return;
               if (t.code >= FUNC_BASE) begin
                  push_op(t.code);
                  prev_cls = (t.code == CODE_NEG) ? PC_OPER : PC_OTHER;
               end else if (t.code == OP_SUB && ((!emitted && depth == 0) ||
                                                 prev_cls == PC_LBR || prev_cls == PC_OPER)) begin
                  push_op(CODE_NEG);
                  prev_cls = PC_OPER;
               end else begin
                  while (depth != 0 && outranks(stack_mem[depth - 1], t.code)) begin
                     depth--;
                     emit(OK_OPER, stack_mem[depth], '0, '0, ERR_NONE, 1'b0);
                  end
                  push_op(t.code);
                  prev_cls = PC_OPER;
               end
            end
            TK_LBR: begin
               push_op(BRACKET_MARK);
               prev_cls = PC_LBR;
            end
            TK_RBR: begin
               unwind_to_bracket();
               if (depth == 0) begin
                  flag_error(ERR_NO_LBR);
               end else begin
                  // drop the bracket, then pop a function or operator sitting above it
                  depth--;
                  if (depth != 0 && stack_mem[depth - 1] != BRACKET_MARK) begin
                     depth--;
                     emit(OK_OPER, stack_mem[depth], '0, '0, ERR_NONE, 1'b0);
                  end
               end
               prev_cls = PC_OTHER;
            end
            default: begin
               unwind_to_bracket();
               prev_cls = PC_OTHER;
            end
         endcase
      endfunction

      task report_mismatch(input string msg);
         if (mismatches < PRINT_LIMIT) $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      task compare_field(input string field, input logic [63:0] got, input logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      checked, field, got, want));
      endtask

      // Compare one accepted result against the oldest expectation
      task check_result(input rpn_token_type got);
         rpn_token_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d code %0d",
                                      got.kind, got.code));
            return;
         end
         want = expected_q.pop_front();
         compare_field("out_kind", 64'(got.kind), 64'(want.kind));
         compare_field("out_code", 64'(got.code), 64'(want.code));
         compare_field("out_real", got.re, want.re);
         compare_field("out_imag", got.im, want.im);
         compare_field("error_code", 64'(got.err), 64'(want.err));
         compare_field("last", 64'(got.last), 64'(want.last));
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   itr_req_if req_ch();
   itr_rsp_if rsp_ch();

   infix_to_rpn_shunting_yard_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #5 clock = ~clock;

   rpn_scoreboard sb;
   token_req_type formula_q[$];
   int            sent_count = 0;
   int            rsp_count  = 0;
   bit            req_burst  = 1'b0;
   bit            rsp_burst  = 1'b0;
   bit            hold_armed = 1'b0;

   function automatic void stage_token(input logic [2:0] kind, input logic [4:0] code = '0,
                                       input logic [63:0] re = '0,
                                       input logic [63:0] im = '0);
      token_req_type t;
      t.kind = kind;
      t.code = code;
      t.re   = re;
      t.im   = im;
      formula_q.push_back(t);
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   function automatic token_req_type random_token();
      token_req_type t;
      t.kind = 3'($urandom_range(0, 7));
      t.code = 5'($urandom_range(0, 31));
      t.re   = rand_word();
      t.im   = rand_word();
      return t;
   endfunction

   // Operand: variable, constant, negation, bracketed or function call
   function automatic void build_term(input int level);
      int pick;
      int args;
      pick = (level >= 4) ? $urandom_range(0, 1) : $urandom_range(0, 5);
      case (pick)
         0: stage_token(TK_VAR);
         1: stage_token(TK_CONST, '0, rand_word(), rand_word());
         2: begin
            stage_token(TK_OPER, OP_SUB);
            build_term(level + 1);
         end
         3: begin
            stage_token(TK_LBR);
            build_expr(level + 1);
            stage_token(TK_RBR);
         end
         default: begin
            stage_token(TK_OPER, 5'($urandom_range(FUNC_BASE, CODE_LIMIT - 1)));
            stage_token(TK_LBR);
            build_expr(level + 1);
            args = $urandom_range(0, 2);
            repeat (args) begin
               stage_token(TK_COMMA);
               build_expr(level + 1);
            end
            stage_token(TK_RBR);
         end
      endcase
   endfunction

   function automatic void build_expr(input int level);
      int terms;
      build_term(level);
      terms = (level >= 3) ? 0 : $urandom_range(0, 3);
      repeat (terms) begin
         stage_token(TK_OPER, 5'($urandom_range(OP_ADD, OP_POW)));
         build_term(level + 1);
      end
   endfunction

   // Offer one request, after a random idle gap unless bursting, and hold it until accepted
   task automatic drive_request(input token_req_type t);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.token_kind <= t.kind;
      req_ch.op_code    <= t.code;
      req_ch.const_real <= t.re;
      req_ch.const_imag <= t.im;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(t);
      sent_count++;
   endtask

   // Send the staged formula, optionally sprinkling junk and dropping tokens
   task automatic send_formula(input bit noisy);
      foreach (formula_q[i]) begin
         if (noisy && $urandom_range(0, 19) == 0) drive_request(random_token());
         if (!(noisy && $urandom_range(0, 24) == 0)) drive_request(formula_q[i]);
      end
      formula_q.delete();
   endtask

   task automatic run_directed();
      // empty formula
      stage_token(TK_END);
      send_formula(1'b0);
      // unary minus at start and after a bracket, right-associative power, junk kind
      stage_token(TK_OPER, OP_SUB);
      stage_token(TK_VAR);
      stage_token(TK_OPER, OP_POW);
      stage_token(TK_CONST, '0, ALL_ONES, '0);
      stage_token(TK_OPER, OP_POW);
      stage_token(TK_LBR);
      stage_token(TK_OPER, OP_SUB);
      stage_token(TK_CONST, '0, '0, ALL_ONES);
      stage_token(TK_RBR);
      stage_token(TK_OPER, OP_DIV);
      stage_token(TK_BAD, OP_MUL, ALL_ONES, ALL_ONES);
      stage_token(TK_VAR);
      stage_token(TK_END);
      send_formula(1'b0);
      // function with arguments, out-of-range code, unmatched right bracket
      stage_token(TK_OPER, CODE_LIMIT - 5'd1);
      stage_token(TK_LBR);
      stage_token(TK_VAR);
      stage_token(TK_COMMA);
      stage_token(TK_OPER, OP_UNUSED);
      stage_token(TK_VAR);
      stage_token(TK_RBR);
      stage_token(TK_RBR);
      stage_token(TK_VAR);
      stage_token(TK_END);
      send_formula(1'b0);
      // unclosed bracket
      stage_token(TK_LBR);
      stage_token(TK_END);
      send_formula(1'b0);
   endtask

   task automatic run_random();
      int base;
      int f;
      base = sent_count;
      f = 0;
      while (sent_count - base < RANDOM_ITEMS) begin
         req_burst = ($urandom_range(0, 4) == 0);
         if (f == 2) hold_armed = 1'b1;
         case (f)
            1: begin
               // fill the stack with negations, then flush it all at end
               repeat (STACK_DEPTH) stage_token(TK_OPER, OP_SUB);
               stage_token(TK_VAR);
               stage_token(TK_END);
               send_formula(1'b0);
            end
            3: begin
               // nest one bracket too deep
               repeat (STACK_DEPTH + 1) stage_token(TK_LBR);
               stage_token(TK_VAR);
               stage_token(TK_END);
               send_formula(1'b0);
            end
            6: begin
               // push the operand balance past its top
               repeat (int'(BAL_MAX) + 1) stage_token(TK_VAR, '0, rand_word(), rand_word());
               stage_token(TK_END);
               send_formula(1'b0);
            end
            default: begin
               build_expr(0);
               stage_token(TK_END);
               send_formula($urandom_range(0, 3) == 0);
            end
         endcase
         f++;
      end
   endtask

   // Result side: random stalls, burst stretches and one long hold-off
   initial begin
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_armed) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_armed = 1'b0;
         end else begin
            stall = rsp_burst ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         sb.check_result('{kind: rsp_ch.out_kind, code: rsp_ch.out_code,
                           re: rsp_ch.out_real, im: rsp_ch.out_imag,
                           err: rsp_ch.error_code, last: rsp_ch.last});
         rsp_count++;
         if (rsp_count % 40 == 0) rsp_burst = ($urandom_range(0, 3) == 0);
      end
   end

   // Stimulus and end of run
   initial begin
      sb = new();
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.token_kind <= TK_VAR;
      req_ch.op_code    <= OP_ADD;
      req_ch.const_real <= '0;
      req_ch.const_imag <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #10_000_000;
      $display("TIMEOUT: %0d results still expected", sb.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
